// ----- hw/rtl/oaht_pkg.sv -----
// oaht_pkg: shared types, codes and constants of the open-addressing hash set
// no dependencies; compiled first
package oaht_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int KEY_W = 31;
	localparam int OP_W = 2;
	localparam int TS_W = 11;
	localparam int MODE_W = 2;
	localparam int PC_W = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 11;
	// digit-reversed magnitude of a 31-bit key stays below 10^10
	localparam int REV_W = 34;
	localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
	localparam int DIV10_SHIFT = 35;
	localparam int RADIX = 10;

	localparam logic [TS_W-1:0] TS_RESET = 11'd1024;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE = 1'b1;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
	// unused opcode: no change, result is a plain failure
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;

	localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_QUAD = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;
	// spare mode code, behaves as linear
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	localparam logic [1:0] SLOT_EMPTY = 2'd0;
	localparam logic [1:0] SLOT_OCCUPIED = 2'd1;
	localparam logic [1:0] SLOT_DELETED = 2'd2;

	typedef struct packed {
		logic [1:0] status;
		logic [KEY_W-1:0] key;
	} slot_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_KMOD_GO,
		ST_KMOD_WAIT,
		ST_REV_GO,
		ST_REV_WAIT,
		ST_RMOD_GO,
		ST_RMOD_WAIT,
		ST_PADDR,
		ST_PCHK,
		ST_RESULT
	} state_t;

endpackage

// ----- hw/rtl/oaht_if.sv -----
// oaht_req_if / oaht_rsp_if: valid/ready channels of the hash set
// depends on oaht_pkg
interface oaht_req_if import oaht_pkg::*; ();
	logic valid;
	logic ready;
	logic [OP_W-1:0] opcode;
	logic signed [KEY_W-1:0] key;

	modport source (output valid, opcode, key, input ready);
	modport sink (input valid, opcode, key, output ready);
endinterface

interface oaht_rsp_if import oaht_pkg::*; ();
	logic valid;
	logic ready;
	logic success;
	logic [PC_W-1:0] probe_count;

	modport source (output valid, success, probe_count, input ready);
	modport sink (input valid, success, probe_count, output ready);
endinterface

// ----- hw/rtl/open_addressing_hash_table_top.sv -----
// open_addressing_hash_table_top: open-addressing hash set, sequencer and probe arithmetic
// depends on oaht_pkg, oaht_if, oaht_rev, oaht_mod, oaht_mem
//
// req channel carries one word per operation: opcode (insert, remove, search) and a
// signed key. rsp channel returns exactly one word per operation: success and, for a
// search, the number of slots examined. Configuration (table_size, probe_mode) is
// written through cfg_we/cfg_idx/cfg_data; the user must write it only while no
// operation is in flight, the block does not enforce this. After reset the slot
// store is swept to empty, one slot a cycle, with req.ready low. One operation is
// handled at a time: req.ready is high only while idle. Per operation: intake, key
// mod table_size in the shared remainder unit, in double mode also digit reversal
// and the reversed key mod table_size, then for each probe an address step and a
// registered slot read, then the output register. Probes run up to table_size per
// operation. The result sits in the output register; if rsp is stalled the next
// operation is still accepted and waits at its end until the register frees.
module open_addressing_hash_table_top import oaht_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	oaht_req_if.sink req,
	oaht_rsp_if.source rsp
);

	localparam int NW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = (NW > TS_W) ? NW : TS_W;

	state_t state_q, state_d;

	logic [TS_W-1:0] ts_q;
	logic [MODE_W-1:0] mode_q;

	logic [OP_W-1:0] op_q;
	logic [KEY_W-1:0] key_q;
	logic [NW-1:0] n_q;
	logic dbl_q;
	logic quad_q;
	logic [NW-1:0] am_q;
	logic [NW-1:0] rm_q;
	logic [NW-1:0] i_q;
	logic [NW-1:0] q_q;
	logic [NW-1:0] d_q;
	logic [NW-1:0] g_q;
	logic big_q;
	logic [AW-1:0] first_q;
	logic [AW-1:0] loc_q;
	logic succ_q;
	logic [NW-1:0] pc_q;
	logic [AW-1:0] clr_q;

	logic out_valid_q;
	logic out_succ_q;
	logic [PC_W-1:0] out_pc_q;

	logic accept;
	logic out_load;
	logic neg;
	logic [KEY_W-1:0] key_mag;
	logic [CW-1:0] ts_ext;
	logic [NW-1:0] n_eff;

	logic mod_start;
	logic mod_done;
	logic [REV_W-1:0] mod_x;
	logic [NW-1:0] mod_rem;
	logic rev_start;
	logic rev_done;
	logic [REV_W-1:0] rev_val;

	logic [NW-1:0] fm;
	logic f_exact;
	logic [NW:0] t;
	logic [NW:0] t_red;
	logic [AW-1:0] loc;

	logic [NW:0] q_sum, d_sum, g_sum;
	logic [NW+1:0] sq_chk;
	logic [NW-1:0] i_nx;

	slot_t rd;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	slot_t mem_wdata;
	logic hit_first, occ, match;
	logic fin, fin_succ, advance;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_RESULT) && (!out_valid_q || rsp.ready);

	assign neg = key_q[KEY_W-1];
	assign key_mag = neg ? (~key_q + KEY_W'(1)) : key_q;

	// effective table size: zero acts as one, clipped to capacity
	always_comb begin
		ts_ext = CW'(ts_q);
		if (ts_ext == '0) begin
			n_eff = NW'(1);
		end else if (ts_ext > CW'(CAPACITY)) begin
			n_eff = NW'(CAPACITY);
		end else begin
			n_eff = NW'(ts_ext);
		end
	end

	assign mod_start = (state_q == ST_KMOD_GO) || (state_q == ST_RMOD_GO);
	assign mod_x = (state_q == ST_RMOD_GO) ? rev_val : REV_W'(key_mag);
	assign rev_start = (state_q == ST_REV_GO);

	oaht_rev u_rev (
		.clk(clk),
		.arst_n(arst_n),
		.start(rev_start),
		.mag(key_mag),
		.done(rev_done),
		.rev(rev_val)
	);

	oaht_mod #(.NW(NW)) u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.start(mod_start),
		.dividend(mod_x),
		.divisor(n_q),
		.done(mod_done),
		.rem(mod_rem)
	);

	// probe slot from |key| mod n and the running f(i) mod n
	always_comb begin
		fm = quad_q ? q_q : i_q;
		f_exact = quad_q ? !big_q : 1'b1;
		if (dbl_q) begin
			t = {1'b0, am_q} + {1'b0, g_q};
		end else if (!neg) begin
			t = {1'b0, am_q} + {1'b0, fm};
		end else if (f_exact && fm < am_q) begin
			// sum still negative: its magnitude is |a| - f
			t = {1'b0, am_q} - {1'b0, fm};
		end else begin
			t = ({1'b0, n_q} - {1'b0, am_q}) + {1'b0, fm};
		end
		t_red = (t >= {1'b0, n_q}) ? (t - {1'b0, n_q}) : t;
		loc = AW'(t_red);
	end

	// next f(i+1) mod n terms
	always_comb begin
		q_sum = {1'b0, q_q} + {1'b0, d_q};
		d_sum = {1'b0, d_q} + (NW+1)'(2);
		g_sum = {1'b0, g_q} + {1'b0, rm_q};
		sq_chk = (NW+2)'(q_q) + (NW+2)'({i_q, 1'b1});
		i_nx = i_q + NW'(1);
	end

	oaht_mem #(.CAPACITY(CAPACITY)) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(loc),
		.rdata(rd)
	);

	assign hit_first = (i_q != '0) && (loc_q == first_q);
	assign occ = (rd.status == SLOT_OCCUPIED);
	assign match = occ && (rd.key == key_q);

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_waddr = loc_q;
		mem_wdata = '{status: SLOT_OCCUPIED, key: key_q};
		fin = 1'b0;
		fin_succ = 1'b0;
		advance = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '{status: SLOT_EMPTY, key: '0};
				if (clr_q == AW'(CAPACITY - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (req.opcode == OP_INSERT || req.opcode == OP_REMOVE ||
					    req.opcode == OP_SEARCH) begin
						state_d = ST_KMOD_GO;
					end else begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_KMOD_GO: state_d = ST_KMOD_WAIT;
			ST_KMOD_WAIT: begin
				if (mod_done) begin
					state_d = dbl_q ? ST_REV_GO : ST_PADDR;
				end
			end
			ST_REV_GO: state_d = ST_REV_WAIT;
			ST_REV_WAIT: begin
				if (rev_done) begin
					state_d = ST_RMOD_GO;
				end
			end
			ST_RMOD_GO: state_d = ST_RMOD_WAIT;
			ST_RMOD_WAIT: begin
				if (mod_done) begin
					state_d = ST_PADDR;
				end
			end
			ST_PADDR: state_d = ST_PCHK;
			ST_PCHK: begin
				priority if (hit_first) begin
					fin = 1'b1;
				end else if (op_q == OP_INSERT && match) begin
					fin = 1'b1;
				end else if (op_q == OP_INSERT && !occ) begin
					fin = 1'b1;
					fin_succ = 1'b1;
					mem_we = 1'b1;
				end else if (op_q != OP_INSERT && rd.status == SLOT_EMPTY) begin
					fin = 1'b1;
				end else if (op_q != OP_INSERT && match) begin
					fin = 1'b1;
					fin_succ = 1'b1;
					if (op_q == OP_REMOVE) begin
						mem_we = 1'b1;
						mem_wdata = '{status: SLOT_DELETED, key: key_q};
					end
				end else if (i_nx == n_q) begin
					fin = 1'b1;
				end else begin
					advance = 1'b1;
				end
				state_d = fin ? ST_RESULT : ST_PADDR;
			end
			ST_RESULT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			ts_q <= TS_RESET;
			mode_q <= MODE_LINEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_TABLE_SIZE: ts_q <= TS_W'(cfg_data);
					REG_PROBE_MODE: mode_q <= MODE_W'(cfg_data);
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.opcode;
			key_q <= req.key;
			n_q <= n_eff;
			quad_q <= (mode_q == MODE_QUAD);
			dbl_q <= (mode_q == MODE_DOUBLE);
			succ_q <= 1'b0;
			pc_q <= '0;
		end
		if (state_q == ST_KMOD_GO) begin
			i_q <= '0;
			q_q <= '0;
			d_q <= (n_q == NW'(1)) ? '0 : NW'(1);
			big_q <= 1'b0;
			g_q <= '0;
		end
		if (state_q == ST_KMOD_WAIT && mod_done) begin
			am_q <= mod_rem;
		end
		if (state_q == ST_RMOD_WAIT && mod_done) begin
			rm_q <= mod_rem;
		end
		if (state_q == ST_PADDR) begin
			loc_q <= loc;
			if (i_q == '0) begin
				first_q <= loc;
			end
		end
		if (fin) begin
			succ_q <= fin_succ;
			pc_q <= (op_q == OP_SEARCH) ? i_nx : '0;
		end
		if (advance) begin
			i_q <= i_nx;
			q_q <= (q_sum >= {1'b0, n_q}) ? NW'(q_sum - {1'b0, n_q}) : NW'(q_sum);
			d_q <= (d_sum >= {1'b0, n_q}) ? NW'(d_sum - {1'b0, n_q}) : NW'(d_sum);
			g_q <= (g_sum >= {1'b0, n_q}) ? NW'(g_sum - {1'b0, n_q}) : NW'(g_sum);
			big_q <= big_q || (sq_chk >= (NW+2)'(n_q));
		end
		if (out_load) begin
			out_succ_q <= succ_q;
			out_pc_q <= PC_W'(pc_q);
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.success = out_succ_q;
	assign rsp.probe_count = out_pc_q;

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("word accepted while an operation is in flight");

	a_mod_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_KMOD_WAIT || state_q == ST_RMOD_WAIT))
		else $error("remainder unit finished outside a wait state");

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PCHK) |-> (NW'(loc_q) < n_q))
		else $error("probe slot beyond table size");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_RESULT) |-> !mem_we)
		else $error("slot store written outside clear or probe");
`endif

endmodule

// ----- hw/rtl/oaht_rev.sv -----
// oaht_rev: decimal digit reversal of a key magnitude, one digit per cycle
// depends on oaht_pkg
module oaht_rev import oaht_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [KEY_W-1:0] mag,
	output logic done,
	output logic [REV_W-1:0] rev
);

	logic run_q;
	logic done_q;
	logic [KEY_W-1:0] m_q;
	logic [REV_W-1:0] r_q;
	logic [63:0] prod;
	logic [KEY_W-1:0] quot;
	logic [KEY_W-1:0] quot10;
	logic [3:0] digit;
	logic [REV_W-1:0] r10;

	// divide by ten through the reciprocal
	assign prod = 64'({1'b0, m_q}) * 64'(DIV10_MAGIC);
	assign quot = KEY_W'(prod >> DIV10_SHIFT);
	assign quot10 = (quot << 3) + (quot << 1);
	assign digit = 4'(m_q - quot10);
	assign r10 = (r_q << 3) + (r_q << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && m_q == '0) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q <= mag;
			r_q <= '0;
		end else if (run_q && m_q != '0) begin
			m_q <= quot;
			r_q <= r10 + REV_W'(digit);
		end
	end

	assign done = done_q;
	assign rev = r_q;

endmodule

// ----- hw/rtl/oaht_mod.sv -----
// oaht_mod: shared restoring remainder unit, one dividend bit per cycle
// depends on oaht_pkg
module oaht_mod import oaht_pkg::*; #(
	parameter int NW = 11
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [REV_W-1:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic done,
	output logic [NW-1:0] rem
);

	localparam int CNT_W = $clog2(REV_W + 1);

	logic run_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REV_W-1:0] x_q;
	logic [NW-1:0] r_q;
	logic [NW-1:0] div_q;
	logic [NW:0] r2;

	assign r2 = {r_q, x_q[REV_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(REV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
			r_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			x_q <= x_q << 1;
			if (r2 >= {1'b0, div_q}) begin
				r_q <= NW'(r2 - {1'b0, div_q});
			end else begin
				r_q <= NW'(r2);
			end
		end
	end

	assign done = done_q;
	assign rem = r_q;

endmodule

// ----- hw/rtl/oaht_mem.sv -----
// oaht_mem: slot store, one write and one registered read port
// depends on oaht_pkg
module oaht_mem import oaht_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(CAPACITY)-1:0] waddr,
	input  slot_t wdata,
	input  logic [$clog2(CAPACITY)-1:0] raddr,
	output slot_t rdata
);

	slot_t mem [CAPACITY];
	slot_t rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

// ----- tb/open_addressing_hash_table_top_tb.sv -----
// open_addressing_hash_table_top_tb: self-checking testbench of the open-addressing hash set
// depends on oaht_pkg, oaht_if and open_addressing_hash_table_top
// directed and random insert/remove/search words, checked against a behavioral hash set
`timescale 1ns / 100ps

module open_addressing_hash_table_top_tb;
	import oaht_pkg::*;

	localparam int CAP = 1024;
	localparam int CYCLE_LIMIT = 20000000;

	typedef struct {
		logic success;
		logic [PC_W-1:0] probe_count;
	} rsp_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	oaht_req_if req ();
	oaht_rsp_if rsp ();

	open_addressing_hash_table_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// behavioral copy of the set
	logic [1:0] set_status [CAP];
	logic signed [KEY_W-1:0] set_key [CAP];
	logic [TS_W-1:0] cur_size;
	logic [MODE_W-1:0] cur_mode;

	rsp_word_t pending_rsp [$];
	int mismatches;
	int cycles;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	longint key_pool [16];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint rev_digits(longint k);
		longint m;
		longint r;
		m = (k < 0) ? -k : k;
		r = 0;
		while (m > 0) begin
			r = r * RADIX + (m % RADIX);
			m = m / RADIX;
		end
		return (k < 0) ? -r : r;
	endfunction

	function automatic int slot_of(longint k, longint rv, int i, int n);
		longint f;
		longint v;
		if (cur_mode == MODE_QUAD)
			f = longint'(i) * i;
		else if (cur_mode == MODE_DOUBLE)
			f = longint'(i) * rv;
		else
			f = i;
		v = ((k % n) + f) % n;
		if (v < 0)
			v = -v;
		return int'(v);
	endfunction

	// walks the probe sequence; returns matching slot or -1
	function automatic int walk_find(longint k, longint rv, int n, output int probes);
		int first;
		int loc;
		first = 0;
		probes = 0;
		for (int i = 0; i < n; i++) begin
			loc = slot_of(k, rv, i, n);
			probes = i + 1;
			if (i == 0)
				first = loc;
			else if (loc == first)
				return -1;
			if (set_status[loc] == SLOT_EMPTY)
				return -1;
			if (set_status[loc] == SLOT_OCCUPIED && longint'(set_key[loc]) == k)
				return loc;
		end
		return -1;
	endfunction

	function automatic rsp_word_t apply_op(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
		rsp_word_t w;
		longint k;
		longint rv;
		int n;
		int loc;
		int first;
		int probes;
		k = key;
		rv = rev_digits(k);
		n = (cur_size == 0) ? 1 : ((cur_size > CAP) ? CAP : int'(cur_size));
		w.success = 1'b0;
		w.probe_count = '0;
		if (op == OP_INSERT) begin
			first = 0;
			for (int i = 0; i < n; i++) begin
				loc = slot_of(k, rv, i, n);
				if (i == 0)
					first = loc;
				else if (loc == first)
					break;
				if (set_status[loc] == SLOT_OCCUPIED && longint'(set_key[loc]) == k)
					break;
				if (set_status[loc] != SLOT_OCCUPIED) begin
					set_key[loc] = key;
					set_status[loc] = SLOT_OCCUPIED;
					w.success = 1'b1;
					break;
				end
			end
		end else if (op == OP_REMOVE) begin
			loc = walk_find(k, rv, n, probes);
			if (loc >= 0) begin
				set_key[loc] = '0;
				set_status[loc] = SLOT_DELETED;
				w.success = 1'b1;
			end
		end else if (op == OP_SEARCH) begin
			loc = walk_find(k, rv, n, probes);
			w.success = (loc >= 0);
			w.probe_count = probes[PC_W-1:0];
		end
		return w;
	endfunction

	task automatic send_word(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.key <= key;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		pending_rsp.push_back(apply_op(op, key));
	endtask

	task automatic drain;
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TABLE_SIZE)
			cur_size = val[TS_W-1:0];
		else
			cur_mode = val[MODE_W-1:0];
	endtask

	// response checker
	always @(posedge clk) begin
		rsp_word_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: success %0b probe_count %0d",
						rsp.success, rsp.probe_count);
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.success !== e.success || rsp.probe_count !== e.probe_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected success %0b probes %0d, got %0b %0d",
							e.success, e.probe_count, rsp.success, rsp.probe_count);
				end
			end
		end
	end

	// receiver stall control, long hold counted down here
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("open_addressing_hash_table_top_tb: FAIL");
			$finish;
		end
	end

	function automatic logic signed [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return KEY_W'(key_pool[$urandom_range(15)]);
		else if (r < 90)
			return KEY_W'($urandom());
		else
			return KEY_W'($signed($urandom_range(2000)) - 1000);
	endfunction

	function automatic logic [OP_W-1:0] pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return OP_INSERT;
		else if (r < 65)
			return OP_REMOVE;
		else if (r < 95)
			return OP_SEARCH;
		else
			return OP_NOP;
	endfunction

	task automatic test_directed;
		write_reg(REG_TABLE_SIZE, 11'd8);
		write_reg(REG_PROBE_MODE, MODE_LINEAR);
		send_word(OP_INSERT, 31'sd5);
		send_word(OP_INSERT, 31'sd5); // duplicate
		send_word(OP_INSERT, -31'sd5);
		send_word(OP_INSERT, 31'sd13); // collides with 5
		send_word(OP_SEARCH, 31'sd13);
		send_word(OP_REMOVE, 31'sd5);
		send_word(OP_SEARCH, 31'sd13); // walks past a deleted slot
		send_word(OP_REMOVE, 31'sd5);
		send_word(OP_SEARCH, 31'sd5);
		send_word(OP_INSERT, 31'sd999999999);
		send_word(OP_INSERT, -31'sd999999999);
		send_word(OP_INSERT, 31'h3fffffff);
		send_word(OP_INSERT, 31'h40000000);
		send_word(OP_SEARCH, 31'h40000000);
		send_word(OP_SEARCH, 31'sd77);
		send_word(OP_NOP, 31'sd13);
		send_word(OP_INSERT, 31'sd0);
		send_word(OP_INSERT, 31'sd21); // wraps, takes the last free slot
		send_word(OP_SEARCH, 31'sd21);
		write_reg(REG_TABLE_SIZE, 11'd1);
		send_word(OP_INSERT, 31'sd3);
		send_word(OP_INSERT, 31'sd4);
		send_word(OP_SEARCH, 31'sd4);
		send_word(OP_REMOVE, 31'sd3);
	endtask

	task automatic test_random(int size, int mode, int s_idle, int r_stall, int count);
		for (int i = 0; i < 16; i++)
			key_pool[i] = longint'($signed($urandom_range(4 * size + 8)) - (2 * size + 4));
		key_pool[0] = longint'($urandom_range(999999999));
		key_pool[1] = -longint'($urandom_range(999999999));
		write_reg(REG_TABLE_SIZE, size[CFG_DATA_W-1:0]);
		write_reg(REG_PROBE_MODE, mode[CFG_DATA_W-1:0]);
		send_idle_pct = s_idle;
		recv_stall_pct = r_stall;
		for (int i = 0; i < count; i++)
			send_word(pick_op(), pick_key());
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure;
		write_reg(REG_TABLE_SIZE, 11'd9);
		write_reg(REG_PROBE_MODE, MODE_QUAD);
		hold_cycles = 3000;
		for (int i = 0; i < 30; i++)
			send_word(pick_op(), pick_key());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.opcode = '0;
		req.key = '0;
		rsp.ready = 1'b0;
		mismatches = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		cur_size = TS_RESET;
		cur_mode = MODE_LINEAR;
		for (int i = 0; i < CAP; i++) begin
			set_status[i] = SLOT_EMPTY;
			set_key[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// wait out the clearing sweep
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		test_directed();
		test_random(7, MODE_LINEAR, 0, 0, 80);
		test_random(16, MODE_QUAD, 82, 0, 80);
		test_random(11, MODE_DOUBLE, 0, 82, 80);
		test_random(1024, MODE_LINEAR, 13, 13, 60);
		test_random(0, MODE_SPARE, 0, 0, 40);
		test_random(2047, MODE_DOUBLE, 82, 0, 50);
		test_random(1, MODE_QUAD, 0, 82, 40);
		test_random(13, MODE_DOUBLE, 13, 13, 80);
		test_random(5, MODE_QUAD, 0, 0, 80);
		test_random(32, MODE_DOUBLE, 0, 0, 60);
		test_backpressure();
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("open_addressing_hash_table_top_tb: PASS");
		end else begin
			$display("open_addressing_hash_table_top_tb: FAIL");
		end
		$finish;
	end

endmodule
